FILE: hw/rtl/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types, widths and helpers for the round rendezvous table unit.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int OpW     = 2;
  localparam int SeatW   = 4;
  localparam int RoundW  = 32;
  localparam int WordW   = 16;
  localparam int MaskW   = 4;
  localparam int MaxSeats = 4;

  localparam int DefaultSlotCount = 8;
  localparam int DefaultSeatCount = 4;

  localparam logic [WordW-1:0] AbsentWord = 16'hFFFF;

  typedef enum logic [OpW-1:0] {
    OP_MERGE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // 2**i reduced modulo k, worked out at elaboration (k >= 2)
  function automatic int pow2_mod(input int i, input int k);
    int r;
    r = 1;
    for (int n = 0; n < i; n++) begin
      r = r * 2;
      if (r >= k) begin
        r = r - k;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/round_rendezvous_table_unit.sv
// ----------------------------------------------------------------------------
// round_rendezvous_table_unit
// Slot table where seats deposit one word per round; queries collect them.
// ----------------------------------------------------------------------------
// Each transaction is taken into an input register and resolved against the
// slot table held in flip-flops once the output register is free, with the
// result landing in that output register. One transaction is accepted every
// cycle while results are taken; throughput is one item per cycle. The slot
// is round_number modulo SLOT_COUNT; for a slot count that is not a power of
// two the residue is folded from the round bits at input and finished by a
// short compare-subtract ladder in the table stage. No clearing pass is
// needed after reset.
module round_rendezvous_table_unit
  import rrt_pkg::*;
#(
  parameter int SLOT_COUNT = DefaultSlotCount,
  parameter int SEAT_COUNT = DefaultSeatCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OpW-1:0]    operation_i,
  input  logic [SeatW-1:0]  seat_i,
  input  logic [RoundW-1:0] round_number_i,
  input  logic [WordW-1:0]  data_word_i,
  input  logic [MaskW-1:0]  need_mask_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              slot_ready_o,
  output logic [WordW-1:0]  word_seat0_o,
  output logic [WordW-1:0]  word_seat1_o,
  output logic [WordW-1:0]  word_seat2_o,
  output logic [WordW-1:0]  word_seat3_o,
  output logic              seat_rejected_o
);

  localparam int  IdxW     = $clog2(SLOT_COUNT);
  localparam int  SeatIdxW = $clog2(SEAT_COUNT);
  localparam bit  SlotPow2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
  localparam int  PreW     = SlotPow2 ? IdxW : $clog2(RoundW * (SLOT_COUNT - 1) + 1);
  localparam int  LadW     = PreW + IdxW + 1;

  typedef logic [SEAT_COUNT-1:0][WordW-1:0] row_t;

  // input register
  logic              in_valid_q;
  op_e               op_q;
  logic [SeatW-1:0]  seat_q;
  logic [RoundW-1:0] round_q;
  logic [WordW-1:0]  word_q;
  logic [MaskW-1:0]  need_q;
  logic [PreW-1:0]   pre_d, pre_q;

  // slot table
  logic [SLOT_COUNT-1:0]                 used_q;
  logic [SLOT_COUNT-1:0][SEAT_COUNT-1:0] mask_q;
  logic [RoundW-1:0]                     tag_q   [SLOT_COUNT];
  row_t                                  words_q [SLOT_COUNT];

  // output register
  logic              out_valid_q;
  logic              slot_ready_q, slot_ready_d;
  logic [WordW-1:0]  w0_q, w1_q, w2_q, w3_q;
  logic [WordW-1:0]  w0_d, w1_d, w2_d, w3_d;
  logic              rej_q, rej_d;

  logic              advance;
  logic              accept;
  logic [IdxW-1:0]   slot_idx;
  logic              hit;
  logic              seat_ok;
  logic              do_merge;
  logic              do_clear;
  logic              q_ready;
  logic [MaskW-1:0]  mask_ext;
  row_t              row_rd;
  row_t              row_wr;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // slot index from round number
  if (SlotPow2) begin : g_idx_pow2
    assign pre_d    = round_number_i[IdxW-1:0];
    assign slot_idx = pre_q;
  end else begin : g_idx_fold
    logic [PreW-1:0] term [RoundW];
    logic [PreW-1:0] fold_sum;
    logic [LadW-1:0] rem;

    for (genvar b = 0; b < RoundW; b++) begin : g_term
      assign term[b] = round_number_i[b] ? PreW'(pow2_mod(b, SLOT_COUNT)) : '0;
    end

    always_comb begin
      fold_sum = '0;
      for (int b = 0; b < RoundW; b++) begin
        fold_sum = fold_sum + term[b];
      end
    end
    assign pre_d = fold_sum;

    always_comb begin
      rem = LadW'(pre_q);
      for (int j = PreW - 1; j >= 0; j--) begin
        if (rem >= (LadW'(SLOT_COUNT) << j)) begin
          rem = rem - (LadW'(SLOT_COUNT) << j);
        end
      end
    end
    assign slot_idx = rem[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(operation_i);
      seat_q  <= seat_i;
      round_q <= round_number_i;
      word_q  <= data_word_i;
      need_q  <= need_mask_i;
      pre_q   <= pre_d;
    end
  end

  // table lookup
  assign row_rd   = words_q[slot_idx];
  assign hit      = used_q[slot_idx] && (tag_q[slot_idx] == round_q);
  assign seat_ok  = seat_q < SeatW'(SEAT_COUNT);
  assign do_merge = advance && (op_q == OP_MERGE) && seat_ok;
  assign do_clear = advance && (op_q == OP_CLEAR);
  assign mask_ext = MaskW'(mask_q[slot_idx]);
  assign q_ready  = hit && ((need_q & ~mask_ext) == '0);

  // reclaim fills the row with absent words before the seat word lands
  always_comb begin
    row_wr = hit ? row_rd : {SEAT_COUNT{AbsentWord}};
    row_wr[seat_q[SeatIdxW-1:0]] = word_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      mask_q <= '0;
    end else if (do_clear) begin
      used_q <= '0;
      mask_q <= '0;
    end else if (do_merge) begin
      used_q[slot_idx] <= 1'b1;
      mask_q[slot_idx] <= (hit ? mask_q[slot_idx] : '0)
                          | (SEAT_COUNT'(1) << seat_q[SeatIdxW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_merge) begin
      tag_q[slot_idx]   <= round_q;
      words_q[slot_idx] <= row_wr;
    end
  end

  // result formation
  always_comb begin
    slot_ready_d = 1'b0;
    rej_d        = 1'b0;
    w0_d         = AbsentWord;
    w1_d         = AbsentWord;
    w2_d         = AbsentWord;
    w3_d         = AbsentWord;
    case (op_q)
      OP_MERGE: begin
        rej_d = !seat_ok;
      end
      OP_QUERY: begin
        if (q_ready) begin
          slot_ready_d = 1'b1;
          w0_d = row_rd[0];
          w1_d = row_rd[1];
          if (SEAT_COUNT > 2) begin
            w2_d = row_rd[2 % SEAT_COUNT];
          end
          if (SEAT_COUNT > 3) begin
            w3_d = row_rd[3 % SEAT_COUNT];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      slot_ready_q <= slot_ready_d;
      w0_q         <= w0_d;
      w1_q         <= w1_d;
      w2_q         <= w2_d;
      w3_q         <= w3_d;
      rej_q        <= rej_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_ready_o    = slot_ready_q;
  assign word_seat0_o    = w0_q;
  assign word_seat1_o    = w1_q;
  assign word_seat2_o    = w2_q;
  assign word_seat3_o    = w3_q;
  assign seat_rejected_o = rej_q;

endmodule
